// File: rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

  // pixel and divider widths
  localparam int PixW = 8;
  localparam int DivW = 2 * PixW;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [DivW-1:0] wide_t;

  // hue constants in half-degrees
  localparam logic [6:0] HueOffRed   = 7'd0;
  localparam logic [6:0] HueOffGreen = 7'd60;
  localparam logic [6:0] HueOffBlue  = 7'd120;
  localparam logic [7:0] HueWrap     = 8'd180;
  localparam pix_t       HueMax      = 8'd179;

  // sector holding the largest channel
  typedef enum logic [1:0] {
    SEC_RED   = 2'b00,
    SEC_GREEN = 2'b01,
    SEC_BLUE  = 2'b10
  } sector_t;

  // payload carried through the divider stages
  typedef struct packed {
    wide_t rem_h;
    wide_t rem_s;
    pix_t  quo_h;
    pix_t  quo_s;
    pix_t  chroma;
    pix_t  bright;
  } div_t;

  // one restoring division step
  typedef struct packed {
    wide_t rem;
    logic  qbit;
  } step_t;

  // compare against the divisor aligned at bit 7, subtract, shift left
  function automatic step_t div_step(wide_t rem, pix_t dsr);
    wide_t dsh;
    wide_t diff;
    step_t res;
    dsh = {1'b0, dsr, 7'd0};
    if (rem >= dsh) begin
      diff     = rem - dsh;
      res.qbit = 1'b1;
    end else begin
      diff     = rem;
      res.qbit = 1'b0;
    end
    res.rem = {diff[DivW-2:0], 1'b0};
    return res;
  endfunction

endpackage

// File: rtl/core/rgbhsv_in_if.sv
interface rgbhsv_in_if;
  import rgbhsv_pkg::*;

  logic valid;
  logic ready;
  pix_t red;
  pix_t green;
  pix_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: rtl/core/rgbhsv_out_if.sv
interface rgbhsv_out_if;
  import rgbhsv_pkg::*;

  logic valid;
  logic ready;
  pix_t hue;
  pix_t saturation;
  pix_t brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);
endinterface

// File: rtl/core/rgbhsv_front.sv
module rgbhsv_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  rgbhsv_pkg::pix_t  up_red,
  input  rgbhsv_pkg::pix_t  up_green,
  input  rgbhsv_pkg::pix_t  up_blue,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rgbhsv_pkg::div_t  dn_data
);
  import rgbhsv_pkg::*;

  typedef struct packed {
    pix_t            bright;
    pix_t            chroma;
    sector_t         sector;
    logic signed [8:0] diff;
  } ext_t;

  logic    va_r, va_nxt;
  ext_t    da_r, da_nxt;
  logic    vb_r, vb_nxt;
  div_t    db_r, db_nxt;
  logic    ready_a, ready_b;

  // per-stage handshake
  assign ready_b  = !vb_r || dn_ready;
  assign ready_a  = !va_r || ready_b;
  assign up_ready = ready_a;
  assign va_nxt   = ready_a ? up_valid : va_r;
  assign vb_nxt   = ready_b ? va_r : vb_r;

  // stage a: extremes, sector and channel difference
  always_comb begin
    pix_t mx;
    pix_t mn;
    mx = up_red;
    if (up_green > mx) mx = up_green;
    if (up_blue > mx)  mx = up_blue;
    mn = up_red;
    if (up_green < mn) mn = up_green;
    if (up_blue < mn)  mn = up_blue;
    da_nxt.bright = mx;
    da_nxt.chroma = mx - mn;
    if (up_red >= up_green && up_red >= up_blue) begin
      da_nxt.sector = SEC_RED;
      da_nxt.diff   = $signed({1'b0, up_green}) - $signed({1'b0, up_blue});
    end else if (up_green >= up_blue) begin
      da_nxt.sector = SEC_GREEN;
      da_nxt.diff   = $signed({1'b0, up_blue}) - $signed({1'b0, up_red});
    end else begin
      da_nxt.sector = SEC_BLUE;
      da_nxt.diff   = $signed({1'b0, up_red}) - $signed({1'b0, up_green});
    end
  end

  // stage b: hue and saturation numerators
  always_comb begin
    logic [6:0]         off;
    logic [14:0]        off_prod;
    logic signed [17:0] diff_ext;
    logic signed [17:0] diff_prod;
    logic signed [17:0] num_raw;
    logic signed [17:0] num_fix;
    logic [15:0]        wrap_prod;
    case (da_r.sector)
      SEC_GREEN: off = HueOffGreen;
      SEC_BLUE:  off = HueOffBlue;
      default:   off = HueOffRed;
    endcase
    off_prod  = 15'({8'd0, off} * {7'd0, da_r.chroma});
    diff_ext  = {{9{da_r.diff[8]}}, da_r.diff};
    diff_prod = diff_ext * 18'sd30;
    num_raw   = $signed({3'b000, off_prod}) + diff_prod;
    wrap_prod = {8'd0, da_r.chroma} * {8'd0, HueWrap};
    // wrap a negative hue round the circle
    if (num_raw[17]) begin
      num_fix = num_raw + $signed({2'b00, wrap_prod});
    end else begin
      num_fix = num_raw;
    end
    db_nxt.rem_h  = num_fix[15:0];
    db_nxt.rem_s  = {da_r.chroma, 8'd0} - {8'd0, da_r.chroma};
    db_nxt.quo_h  = '0;
    db_nxt.quo_s  = '0;
    db_nxt.chroma = da_r.chroma;
    db_nxt.bright = da_r.bright;
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && up_valid) begin
      da_r <= da_nxt;
    end
    if (ready_b && va_r) begin
      db_r <= db_nxt;
    end
  end

  assign dn_valid = vb_r;
  assign dn_data  = db_r;

endmodule

// File: rtl/core/rgbhsv_div_step.sv
module rgbhsv_div_step (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  rgbhsv_pkg::div_t  up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output rgbhsv_pkg::div_t  dn_data
);
  import rgbhsv_pkg::*;

  logic  valid_r, valid_nxt;
  div_t  data_r, data_nxt;

  // handshake for this stage
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  // two quotient bits for hue and saturation
  always_comb begin
    step_t h0, h1, s0, s1;
    h0 = div_step(up_data.rem_h, up_data.chroma);
    h1 = div_step(h0.rem, up_data.chroma);
    s0 = div_step(up_data.rem_s, up_data.bright);
    s1 = div_step(s0.rem, up_data.bright);
    data_nxt        = up_data;
    data_nxt.rem_h  = h1.rem;
    data_nxt.rem_s  = s1.rem;
    data_nxt.quo_h  = {up_data.quo_h[PixW-3:0], h0.qbit, h1.qbit};
    data_nxt.quo_s  = {up_data.quo_s[PixW-3:0], s0.qbit, s1.qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: rtl/core/rgb_to_hsv_pixel.sv
// rgb to hsv conversion for 8-bit pixels
//
// in_pix carries one request of red, green and blue; it is taken at a
// rising edge with valid and ready both high. out_pix returns hue in
// half-degrees (0..179), saturation floor(255*chroma/max) and brightness
// (the largest channel), one result for every request, in order.
//
// from acceptance to out_pix.valid a request passes two front stages
// (extremes, then numerators) and four divider stages, each resolving two
// quotient bits of both divisions by restoring steps.
// throughput is one pixel per clock while out_pix.ready is high.
//
// when the receiver stalls, each stage holds its request and ready falls
// back stage by stage; bubbles are squeezed out, nothing is lost or doubled.
// reset (rst_n low, synchronous) clears every stage valid bit; no request
// is in flight afterwards and in_pix.ready is high.
module rgb_to_hsv_pixel (
  input  logic          clk,
  input  logic          rst_n,
  rgbhsv_in_if.sink     in_pix,
  rgbhsv_out_if.source  out_pix
);
  import rgbhsv_pkg::*;

  localparam int NSteps = PixW / 2;

  logic link_valid [NSteps+1];
  logic link_ready [NSteps+1];
  div_t link_data  [NSteps+1];
  div_t fin;

  // extremes and numerators
  rgbhsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_pix.valid),
    .up_ready (in_pix.ready),
    .up_red   (in_pix.red),
    .up_green (in_pix.green),
    .up_blue  (in_pix.blue),
    .dn_valid (link_valid[0]),
    .dn_ready (link_ready[0]),
    .dn_data  (link_data[0])
  );

  // divider chain
  for (genvar k = 0; k < NSteps; k++) begin : g_div
    rgbhsv_div_step u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_data  (link_data[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_data  (link_data[k+1])
    );
  end

  assign fin                 = link_data[NSteps];
  assign link_ready[NSteps]  = out_pix.ready;
  assign out_pix.valid       = link_valid[NSteps];

  // grey and black pixels have no meaningful quotient
  assign out_pix.hue        = (fin.chroma == '0) ? '0 :
                              ((fin.quo_h > HueMax) ? HueMax : fin.quo_h);
  assign out_pix.saturation = (fin.bright == '0) ? '0 : fin.quo_s;
  assign out_pix.brightness = fin.bright;

  // final remainders lie below their divisors
  a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && fin.chroma != '0) |-> (fin.rem_h[DivW-1:PixW] < fin.chroma))
    else $error("hue remainder not below chroma");

  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && fin.bright != '0) |-> (fin.rem_s[DivW-1:PixW] < fin.bright))
    else $error("saturation remainder not below brightness");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_pix.valid && fin.chroma != '0) |-> (fin.quo_h <= HueMax))
    else $error("hue quotient out of range");

  a_chroma_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_pix.valid |-> (fin.chroma <= fin.bright))
    else $error("chroma above brightness");

endmodule

// File: verif/rgb_to_hsv_pixel_tb.sv
module rgb_to_hsv_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgbhsv_pkg::*;

  localparam int NumPhases    = 4;
  localparam int RandPerPhase = 360;
  localparam int DrainCycles  = 20;
  localparam int StallLimit   = 2000;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
  } rgb_req_t;

  typedef struct packed {
    pix_t hue;
    pix_t saturation;
    pix_t brightness;
  } hsv_res_t;

  logic clk;
  logic rst_n;

  rgbhsv_in_if  in_pix ();
  rgbhsv_out_if out_pix ();

  rgb_to_hsv_pixel dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix)
  );

  // pixels waiting for the driver, and converted pixels waiting for the output
  rgb_req_t pending_px[$];
  hsv_res_t expected_hsv[$];

  int send_idle_pct;
  int recv_stall_pct;
  int issued_cnt;
  int accepted_cnt;
  int checked_cnt;
  int err_cnt;
  int quiet_cycles;

  // idle percentages per phase: none, sender, receiver, both
  int phase_send_idle [NumPhases] = '{0, 48, 0, 35};
  int phase_recv_stall[NumPhases] = '{0, 0, 48, 35};

  // corner pixels: black, white, primaries, ties, grey, hue wrap near 180
  rgb_req_t corner_px[22] = '{
    '{8'd0,   8'd0,   8'd0},   '{8'd255, 8'd255, 8'd255},
    '{8'd255, 8'd0,   8'd0},   '{8'd0,   8'd255, 8'd0},
    '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd0},
    '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255},
    '{8'd128, 8'd128, 8'd128}, '{8'd1,   8'd1,   8'd1},
    '{8'd1,   8'd0,   8'd0},   '{8'd0,   8'd1,   8'd0},
    '{8'd0,   8'd0,   8'd1},   '{8'd255, 8'd0,   8'd1},
    '{8'd255, 8'd254, 8'd0},   '{8'd1,   8'd255, 8'd0},
    '{8'd0,   8'd1,   8'd255}, '{8'd1,   8'd1,   8'd0},
    '{8'd0,   8'd1,   8'd1},   '{8'd1,   8'd0,   8'd1},
    '{8'd200, 8'd100, 8'd50},  '{8'd254, 8'd255, 8'd253}
  };

  // exact rgb to hsv conversion, hue in half-degrees
  function automatic hsv_res_t convert_pixel(rgb_req_t px);
    int r;
    int g;
    int b;
    int top;
    int low;
    int chroma;
    int num;
    sector_t sec;
    hsv_res_t res;
    r = int'(px.red);
    g = int'(px.green);
    b = int'(px.blue);
    top = r;
    if (g > top) top = g;
    if (b > top) top = b;
    low = r;
    if (g < low) low = g;
    if (b < low) low = b;
    chroma = top - low;
    res.brightness = pix_t'(top);
    res.saturation = (top == 0) ? '0 : pix_t'((255 * chroma) / top);
    res.hue = '0;
    if (chroma != 0) begin
      // ties go to red, then green
      if (top == r) sec = SEC_RED;
      else if (top == g) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED: begin
          num = int'(HueOffRed) * chroma + 30 * (g - b);
        end
        SEC_GREEN: begin
          num = int'(HueOffGreen) * chroma + 30 * (b - r);
        end
        default: begin
          num = int'(HueOffBlue) * chroma + 30 * (r - g);
        end
      endcase
      if (num < 0) num += int'(HueWrap) * chroma;
      res.hue = pix_t'(num / chroma);
    end
    return res;
  endfunction

  // mostly full-range pixels, with greys, ties, extremes and tiny chroma mixed in
  function automatic rgb_req_t random_pixel();
    rgb_req_t px;
    pix_t extremes[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    px.red   = pix_t'($urandom);
    px.green = pix_t'($urandom);
    px.blue  = pix_t'($urandom);
    case ($urandom_range(9))
      0: begin
        px.green = px.red;
        px.blue  = px.red;
      end
      1: px.green = px.red;
      2: px.blue = px.green;
      3: px.blue = px.red;
      4: begin
        px.red   = extremes[$urandom_range(3)];
        px.green = extremes[$urandom_range(3)];
        px.blue  = extremes[$urandom_range(3)];
      end
      5: begin
        px.green = px.red + pix_t'($urandom_range(2));
        px.blue  = px.red - pix_t'($urandom_range(2));
      end
      default: ;
    endcase
    return px;
  endfunction

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // request driver, one pixel held until taken
  always @(negedge clk) begin : drive_px
    rgb_req_t px;
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
    end else if (!(in_pix.valid && accepted_cnt != issued_cnt)) begin
      if (pending_px.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        px = pending_px.pop_front();
        issued_cnt <= issued_cnt + 1;
        in_pix.valid <= 1'b1;
      end else begin
        px.red   = pix_t'($urandom);
        px.green = pix_t'($urandom);
        px.blue  = pix_t'($urandom);
        in_pix.valid <= 1'b0;
      end
      in_pix.red   <= px.red;
      in_pix.green <= px.green;
      in_pix.blue  <= px.blue;
    end
  end

  // result receiver stalls at random
  always @(negedge clk) begin
    out_pix.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitor: record accepted requests, check results, watch for a hang
  always @(posedge clk) begin : watch_px
    rgb_req_t px;
    hsv_res_t want;
    logic in_fire;
    logic out_fire;
    in_fire  = rst_n && in_pix.valid && in_pix.ready;
    out_fire = rst_n && out_pix.valid && out_pix.ready;
    if (out_fire) begin
      if (expected_hsv.size() == 0) begin
        $display("%0t: unexpected result hue %0d saturation %0d brightness %0d",
                 $time, out_pix.hue, out_pix.saturation, out_pix.brightness);
        err_cnt <= err_cnt + 1;
      end else begin
        want = expected_hsv.pop_front();
        checked_cnt <= checked_cnt + 1;
        if (out_pix.hue !== want.hue ||
            out_pix.saturation !== want.saturation ||
            out_pix.brightness !== want.brightness) begin
          err_cnt <= err_cnt + 1;
        end
        if (out_pix.hue !== want.hue)
          $display("%0t: hue expected %0d actual %0d", $time, want.hue, out_pix.hue);
        if (out_pix.saturation !== want.saturation)
          $display("%0t: saturation expected %0d actual %0d",
                   $time, want.saturation, out_pix.saturation);
        if (out_pix.brightness !== want.brightness)
          $display("%0t: brightness expected %0d actual %0d",
                   $time, want.brightness, out_pix.brightness);
      end
    end
    if (in_fire) begin
      px.red   = in_pix.red;
      px.green = in_pix.green;
      px.blue  = in_pix.blue;
      expected_hsv.push_back(convert_pixel(px));
      accepted_cnt <= accepted_cnt + 1;
    end
    if (in_fire || out_fire) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no request or result moved for %0d cycles", $time, StallLimit);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // phases of stimulus, with a full drain between them
  initial begin
    rst_n          = 1'b0;
    in_pix.valid   = 1'b0;
    in_pix.red     = '0;
    in_pix.green   = '0;
    in_pix.blue    = '0;
    out_pix.ready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    issued_cnt     = 0;
    accepted_cnt   = 0;
    checked_cnt    = 0;
    err_cnt        = 0;
    quiet_cycles   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      @(posedge clk);
      send_idle_pct  = phase_send_idle[ph];
      recv_stall_pct = phase_recv_stall[ph];
      if (ph == 0) begin
        foreach (corner_px[i]) pending_px.push_back(corner_px[i]);
      end
      repeat (RandPerPhase) pending_px.push_back(random_pixel());
      // next phase waits until every result of this phase is back
      while (pending_px.size() > 0 || issued_cnt != accepted_cnt ||
             accepted_cnt != checked_cnt)
        @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
    if (err_cnt == 0 && expected_hsv.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
